@@ hdl/pqr_pkg.sv @@
// shared types, constants and codes of the palette quad reduce block
package pqr_pkg;

  // default palette depth and field widths
  localparam int PQR_ENTRIES     = 256;
  localparam int PQR_CHAN_W      = 8;
  localparam int PQR_INDEX_W     = 8;
  localparam int PQR_COLOR_W     = 3 * PQR_CHAN_W;
  localparam int PQR_DIST_W      = 10;
  localparam int PQR_SUM_W       = PQR_CHAN_W + 2;

  // item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_REDUCE = 1'b1;

  // item state between the front stage and the averaging stage
  typedef struct packed {
    logic                   valid;
    logic                   reduce;
    logic [PQR_INDEX_W-1:0] widx;
    logic [PQR_COLOR_W-1:0] wcolor;
    logic [3:0]             in_range;
  } pqr_front_t;

  // item state carried along the search cells
  typedef struct packed {
    logic                   valid;
    logic                   reduce;
    logic [PQR_INDEX_W-1:0] widx;
    logic [PQR_COLOR_W-1:0] wcolor;
    logic [PQR_CHAN_W-1:0]  avg_r;
    logic [PQR_CHAN_W-1:0]  avg_g;
    logic [PQR_CHAN_W-1:0]  avg_b;
    logic [PQR_INDEX_W-1:0] best_idx;
    logic [PQR_DIST_W-1:0]  best_dist;
  } pqr_item_t;

endpackage

@@ hdl/pqr_ram.sv @@
// generic single write port ram with registered read
module pqr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/pqr_average.sv @@
// averaging stage: sums the four texel colors and shifts right by two
module pqr_average
  import pqr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  pqr_front_t             front,
  input  logic [PQR_COLOR_W-1:0] color [4],
  output pqr_item_t              item
);

  logic [PQR_SUM_W-1:0] sum_r;
  logic [PQR_SUM_W-1:0] sum_g;
  logic [PQR_SUM_W-1:0] sum_b;

  // channel sums, out of range texels count as black
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int t = 0; t < 4; t++) begin
      if (front.in_range[t]) begin
        sum_r = sum_r + PQR_SUM_W'(color[t][3*PQR_CHAN_W-1:2*PQR_CHAN_W]);
        sum_g = sum_g + PQR_SUM_W'(color[t][2*PQR_CHAN_W-1:PQR_CHAN_W]);
        sum_b = sum_b + PQR_SUM_W'(color[t][PQR_CHAN_W-1:0]);
      end
    end
  end

  // valid bit and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (en) begin
      item.valid <= front.valid;
    end
    if (en) begin
      item.reduce    <= front.reduce;
      item.widx      <= front.widx;
      item.wcolor    <= front.wcolor;
      item.avg_r     <= sum_r[PQR_SUM_W-1:2];
      item.avg_g     <= sum_g[PQR_SUM_W-1:2];
      item.avg_b     <= sum_b[PQR_SUM_W-1:2];
      item.best_idx  <= '0;
      item.best_dist <= '0;
    end
  end

endmodule

@@ hdl/pqr_cell.sv @@
// search cell: holds one palette entry and keeps the running best match
module pqr_cell
  import pqr_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  pqr_item_t item_in,
  output pqr_item_t item_out
);

  logic [PQR_COLOR_W-1:0] color;
  logic [PQR_CHAN_W-1:0]  pr;
  logic [PQR_CHAN_W-1:0]  pg;
  logic [PQR_CHAN_W-1:0]  pb;
  logic [PQR_CHAN_W-1:0]  dr;
  logic [PQR_CHAN_W-1:0]  dg;
  logic [PQR_CHAN_W-1:0]  db;
  logic [PQR_DIST_W-1:0]  l1_dist;
  logic                   take;

  assign pr = color[3*PQR_CHAN_W-1:2*PQR_CHAN_W];
  assign pg = color[2*PQR_CHAN_W-1:PQR_CHAN_W];
  assign pb = color[PQR_CHAN_W-1:0];

  // l1 distance from the quad average to this entry
  always_comb begin
    dr      = (item_in.avg_r > pr) ? item_in.avg_r - pr : pr - item_in.avg_r;
    dg      = (item_in.avg_g > pg) ? item_in.avg_g - pg : pg - item_in.avg_g;
    db      = (item_in.avg_b > pb) ? item_in.avg_b - pb : pb - item_in.avg_b;
    l1_dist = PQR_DIST_W'(dr) + PQR_DIST_W'(dg) + PQR_DIST_W'(db);
    take    = (INDEX == 0) || (l1_dist < item_in.best_dist);
  end

  // entry update when a write item passes this cell
  always_ff @(posedge clk) begin
    if (en && item_in.valid && !item_in.reduce &&
        item_in.widx == PQR_INDEX_W'(INDEX)) begin
      color <= item_in.wcolor;
    end
  end

  // valid bit, payload and best match
  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= item_in.valid;
    end
    if (en) begin
      item_out.reduce <= item_in.reduce;
      item_out.widx   <= item_in.widx;
      item_out.wcolor <= item_in.wcolor;
      item_out.avg_r  <= item_in.avg_r;
      item_out.avg_g  <= item_in.avg_g;
      item_out.avg_b  <= item_in.avg_b;
      if (take) begin
        item_out.best_idx  <= PQR_INDEX_W'(INDEX);
        item_out.best_dist <= l1_dist;
      end else begin
        item_out.best_idx  <= item_in.best_idx;
        item_out.best_dist <= item_in.best_dist;
      end
    end
  end

endmodule

@@ hdl/palette_quad_reduce_nearest_core.sv @@
// Palette quad reduce with L1 nearest color search, one cell per palette entry.
// Stages: ram read and front register at the accept edge, one averaging stage,
// then one stage per search cell.
// Throughput: one item per cycle unless the output stalls; writes share the pipeline.
// Reset clears all valid bits; palette contents stay undefined until written.
module palette_quad_reduce_nearest_core
  import pqr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PQR_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   func,
  input  logic [PQR_INDEX_W-1:0] entry_index,
  input  logic [PQR_CHAN_W-1:0]  red,
  input  logic [PQR_CHAN_W-1:0]  green,
  input  logic [PQR_CHAN_W-1:0]  blue,
  input  logic [PQR_INDEX_W-1:0] texel_top_left,
  input  logic [PQR_INDEX_W-1:0] texel_top_right,
  input  logic [PQR_INDEX_W-1:0] texel_bottom_right,
  input  logic [PQR_INDEX_W-1:0] texel_bottom_left,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PQR_INDEX_W-1:0] nearest_index
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic                   en;
  logic                   accept;
  logic                   wr_en;
  logic [PQR_INDEX_W-1:0] texel [4];
  logic [PQR_COLOR_W-1:0] color [4];
  logic [3:0]             in_range;
  pqr_front_t             front;
  pqr_item_t              pipe [PALETTE_ENTRIES+1];

  // global advance: move whenever the output slot is free or being taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign wr_en    = accept && (func == FUNC_WRITE) &&
                    ({1'b0, entry_index} < (PQR_INDEX_W+1)'(PALETTE_ENTRIES));

  assign texel[0] = texel_top_left;
  assign texel[1] = texel_top_right;
  assign texel[2] = texel_bottom_right;
  assign texel[3] = texel_bottom_left;

  // one palette copy per texel read
  for (genvar t = 0; t < 4; t++) begin : g_ram
    assign in_range[t] = ({1'b0, texel[t]} < (PQR_INDEX_W+1)'(PALETTE_ENTRIES));
    pqr_ram #(
      .WIDTH(PQR_COLOR_W),
      .DEPTH(PALETTE_ENTRIES)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en),
      .waddr(entry_index[AW-1:0]),
      .wdata({red, green, blue}),
      .re   (en),
      .raddr(texel[t][AW-1:0]),
      .rdata(color[t])
    );
  end

  // front stage valid bit and payload, aligned with the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      front.valid <= 1'b0;
    end else if (en) begin
      front.valid <= in_valid;
    end
    if (en) begin
      front.reduce   <= (func == FUNC_REDUCE);
      front.widx     <= entry_index;
      front.wcolor   <= {red, green, blue};
      front.in_range <= in_range;
    end
  end

  // average of the quad
  pqr_average u_average (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .front(front),
    .color(color),
    .item (pipe[0])
  );

  // search cells, one per palette entry
  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    pqr_cell #(
      .INDEX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .item_in (pipe[k]),
      .item_out(pipe[k+1])
    );
  end

  // result: only reduce items leave a result
  assign out_valid     = pipe[PALETTE_ENTRIES].valid && pipe[PALETTE_ENTRIES].reduce;
  assign nearest_index = pipe[PALETTE_ENTRIES].best_idx;

endmodule

@@ hdl/pqr_checker.sv @@
// port level checks of the palette quad reduce block and their binding
module pqr_checker
  import pqr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PQR_ENTRIES
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [PQR_INDEX_W-1:0] nearest_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(nearest_index))
    else $error("stalled result changed");

  // result index stays inside the palette
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, nearest_index} < (PQR_INDEX_W+1)'(PALETTE_ENTRIES)))
    else $error("result index beyond palette");

  // input side stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output slot");

  // an offered input item stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before accept");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind palette_quad_reduce_nearest_core pqr_checker #(
  .PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_pqr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .nearest_index(nearest_index)
);

@@ tb/sv/palette_quad_reduce_nearest_core_tb.sv @@
// testbench for the palette quad reduce block: palette fill, directed table, random items
`timescale 1ns / 100ps

module palette_quad_reduce_nearest_core_tb;
  import pqr_pkg::*;

  localparam int DEPTH       = PQR_ENTRIES;
  localparam int LATENCY     = DEPTH + 2;
  localparam int RANDOM_ITEMS = 1220;
  localparam int HOLD_CYCLES = 600;

  // one input item of the stimulus table
  typedef struct {
    logic                   op;
    logic [PQR_INDEX_W-1:0] widx;
    logic [PQR_CHAN_W-1:0]  r, g, b;
    logic [PQR_INDEX_W-1:0] tl, tr, br, bl;
    bit                     typed;
    logic [PQR_INDEX_W-1:0] want;
  } quad_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = FUNC_WRITE;
  logic [PQR_INDEX_W-1:0] entry_index = '0;
  logic [PQR_CHAN_W-1:0]  red = '0, green = '0, blue = '0;
  logic [PQR_INDEX_W-1:0] texel_top_left = '0, texel_top_right = '0;
  logic [PQR_INDEX_W-1:0] texel_bottom_right = '0, texel_bottom_left = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PQR_INDEX_W-1:0] nearest_index;

  // predictor state and bookkeeping
  logic [PQR_COLOR_W-1:0] shadow_palette [DEPTH];
  logic [PQR_INDEX_W-1:0] pending_nearest [$];
  int errors = 0;
  int writes_sent = 0;
  int reduces_sent = 0;
  int nearest_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 0;

  palette_quad_reduce_nearest_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .entry_index(entry_index),
    .red(red), .green(green), .blue(blue),
    .texel_top_left(texel_top_left), .texel_top_right(texel_top_right),
    .texel_bottom_right(texel_bottom_right), .texel_bottom_left(texel_bottom_left),
    .out_valid(out_valid), .out_ready(out_ready),
    .nearest_index(nearest_index)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

  // average the quad and search the palette for the least L1 distance, lowest index wins
  function automatic logic [PQR_INDEX_W-1:0] nearest_of_quad(input quad_item_t it);
    int unsigned sum_r, sum_g, sum_b, avg_r, avg_g, avg_b, l1_dist, best_dist;
    int unsigned pr, pg, pb;
    logic [PQR_INDEX_W-1:0] texels [4];
    logic [PQR_COLOR_W-1:0] c;
    logic [PQR_INDEX_W-1:0] best;
    sum_r = 0; sum_g = 0; sum_b = 0;
    texels = '{it.tl, it.tr, it.br, it.bl};
    foreach (texels[k]) begin
      c = shadow_palette[texels[k]];
      sum_r += 32'(c[23:16]);
      sum_g += 32'(c[15:8]);
      sum_b += 32'(c[7:0]);
    end
    avg_r = sum_r >> 2;
    avg_g = sum_g >> 2;
    avg_b = sum_b >> 2;
    best = '0;
    best_dist = 0;
    for (int i = 0; i < DEPTH; i++) begin
      c = shadow_palette[i];
      pr = 32'(c[23:16]);
      pg = 32'(c[15:8]);
      pb = 32'(c[7:0]);
      l1_dist = ((avg_r > pr) ? avg_r - pr : pr - avg_r)
              + ((avg_g > pg) ? avg_g - pg : pg - avg_g)
              + ((avg_b > pb) ? avg_b - pb : pb - avg_b);
      if (i == 0 || l1_dist < best_dist) begin
        best_dist = l1_dist;
        best = i[PQR_INDEX_W-1:0];
      end
    end
    return best;
  endfunction

  // offer one item until accepted, then record what it should produce
  task automatic send_item(input quad_item_t it);
    logic [PQR_INDEX_W-1:0] predicted;
    in_valid           <= 1'b1;
    func               <= it.op;
    entry_index        <= it.widx;
    red                <= it.r;
    green              <= it.g;
    blue               <= it.b;
    texel_top_left     <= it.tl;
    texel_top_right    <= it.tr;
    texel_bottom_right <= it.br;
    texel_bottom_left  <= it.bl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op == FUNC_WRITE) begin
      shadow_palette[it.widx] = {it.r, it.g, it.b};
      writes_sent++;
    end else begin
      predicted = nearest_of_quad(it);
      if (it.typed && predicted !== it.want)
        $display("note: table row expects %0d, predictor gives %0d", it.want, predicted);
      pending_nearest.push_back(it.typed ? it.want : predicted);
      reduces_sent++;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic quad_item_t wr(int idx, int r, int g, int b);
    quad_item_t it;
    it = '{FUNC_WRITE, PQR_INDEX_W'(idx), PQR_CHAN_W'(r), PQR_CHAN_W'(g), PQR_CHAN_W'(b),
           PQR_INDEX_W'($urandom), PQR_INDEX_W'($urandom), PQR_INDEX_W'($urandom),
           PQR_INDEX_W'($urandom), 1'b0, '0};
    return it;
  endfunction

  function automatic quad_item_t rd(int tl, int tr, int br, int bl, bit typed, int want);
    quad_item_t it;
    it = '{FUNC_REDUCE, PQR_INDEX_W'($urandom), PQR_CHAN_W'($urandom),
           PQR_CHAN_W'($urandom), PQR_CHAN_W'($urandom),
           PQR_INDEX_W'(tl), PQR_INDEX_W'(tr), PQR_INDEX_W'(br), PQR_INDEX_W'(bl),
           typed, PQR_INDEX_W'(want)};
    return it;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      nearest_seen++;
      if (pending_nearest.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d", $time, nearest_index);
      end else begin
        if (nearest_index !== pending_nearest[0]) begin
          errors++;
          $display("%0t: nearest_index mismatch, expected %0d, actual %0d",
                   $time, pending_nearest[0], nearest_index);
        end
        void'(pending_nearest.pop_front());
      end
    end
  end

  initial begin
    quad_item_t directed [$];
    quad_item_t it;
    int wait_cycles;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // gray ramp palette, every entry written before any reduce
    for (int i = 0; i < DEPTH; i++) send_item(wr(i, i, i, i));

    // directed rows: extremes, truncation, ties, ignored fields
    directed.push_back(rd(0, 0, 0, 0, 1, 0));
    directed.push_back(rd(255, 255, 255, 255, 1, 255));
    directed.push_back(rd(0, 255, 255, 0, 1, 127));
    directed.push_back(rd(255, 0, 0, 0, 1, 63));
    directed.push_back(rd(1, 2, 3, 4, 1, 2));
    directed.push_back(wr(200, 5, 5, 5));
    directed.push_back(rd(5, 5, 5, 5, 1, 5));
    directed.push_back(rd(200, 200, 200, 200, 1, 5));
    directed.push_back(wr(0, 255, 0, 0));
    directed.push_back(rd(0, 0, 0, 0, 1, 0));
    directed.push_back(wr(255, 0, 255, 255));
    directed.push_back(rd(255, 255, 255, 255, 1, 255));
    directed.push_back(wr(17, 255, 255, 255));
    directed.push_back(wr(18, 0, 0, 0));
    directed.push_back(rd(17, 17, 18, 18, 0, 0));
    directed.push_back(rd(0, 17, 255, 200, 0, 0));
    directed.push_back(wr(128, 170, 85, 170));
    directed.push_back(rd(128, 128, 128, 0, 0, 0));
    directed.push_back(rd(255, 0, 255, 17, 0, 0));
    directed.push_back(wr(1, 85, 170, 85));
    directed.push_back(rd(1, 1, 128, 128, 0, 0));
    foreach (directed[k]) send_item(directed[k]);

    // random part in three phases of idling; the last one starts with a long hold-off
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        tx_idle_pct = 9; rx_idle_pct = 63;
      end else if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 63; rx_idle_pct = 9;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
        hold_req = 1;
      end
      if ($urandom_range(99) < 30)
        it = wr($urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(255));
      else
        it = rd($urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(255), 0, 0);
      send_item(it);
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    wait_cycles = 0;
    while (pending_nearest.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (pending_nearest.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected %0d, actual none",
               $time, pending_nearest.size(), pending_nearest[0]);
    end

    $display("covered %0d palette writes and %0d quad reductions, %0d results checked",
             writes_sent, reduces_sent, nearest_seen);
    $display("idling on both sides, a long output hold-off, %0d mismatches", errors);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
